### hdl/linear_probe_hash_map_assert.svh
// Assertion macros for the hash map top level
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset
`define LPHM_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hash map check failed");

// Next-cycle implication, sampled on clock, off during reset
`define LPHM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hash map check failed");

`endif

### hdl/lphm_pkg.sv
// Shared constants, types and codes for the linear probing hash map
`timescale 1ns / 1ps
`default_nettype none

package lphm_pkg;

   // Table geometry
   localparam int unsigned CAPACITY   = 64;
   localparam int unsigned SLOT_W     = $clog2(CAPACITY);
   localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

   // Field widths
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned KEY_W      = 32;
   localparam int unsigned HASH_W     = 32;
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned OUT_SLOT_W = 6;
   localparam int unsigned COUNT_W    = 7;

   // Control register block
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam int unsigned REG_MAX_ENTRIES = 0;
   localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 7'd48;

   // Reciprocal for hash mod CAPACITY: floor(h * M >> SH) is exact for 32-bit h
   localparam int unsigned RECIP_SH = HASH_W + SLOT_W;
   localparam int unsigned RECIP_W  = HASH_W + 1;
   localparam int unsigned PROD_W   = HASH_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SH) + CAPACITY - 1) / CAPACITY;
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_FULL);

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_DELETED = 2'd1,
      SLOT_USED    = 2'd2
   } slot_state_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET          = 2'd0,
      CMD_SET_EXISTING = 2'd1,
      CMD_GET          = 2'd2,
      CMD_DELETE       = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // State and key share one memory word
   typedef struct packed {
      slot_state_type     state;
      logic [KEY_W-1:0]   key;
   } slot_word_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  addr;
   } rd_req_type;

   typedef struct packed {
      slot_state_type     state;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } rd_rsp_type;

   typedef struct packed {
      logic               slot_we;
      logic               value_we;
      logic [SLOT_W-1:0]  addr;
      slot_state_type     state;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } wr_req_type;

endpackage

`default_nettype wire

### hdl/lphm_table.sv
// Slot storage: state/key memory, value memory and per-slot valid bits
`timescale 1ns / 1ps
`default_nettype none

module lphm_table (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lphm_pkg::rd_req_type rd_req,
   output lphm_pkg::rd_rsp_type     rd_rsp,
   input  wire lphm_pkg::wr_req_type wr_req
);

   lphm_pkg::slot_word_type           slot_mem  [lphm_pkg::CAPACITY];
   logic [lphm_pkg::VALUE_W-1:0]      value_mem [lphm_pkg::CAPACITY];

   logic [lphm_pkg::CAPACITY-1:0]     live_ff;
   logic                              live_rd_ff;
   lphm_pkg::slot_word_type           slot_rd_ff;
   logic [lphm_pkg::VALUE_W-1:0]      value_rd_ff;

   // Write and read the state/key memory
   always_ff @(posedge clock) begin
      if (wr_req.slot_we) begin
         slot_mem[wr_req.addr] <= '{state: wr_req.state, key: wr_req.key};
      end
      if (rd_req.en) begin
         slot_rd_ff <= slot_mem[rd_req.addr];
      end
   end

   // Write and read the value memory
   always_ff @(posedge clock) begin
      if (wr_req.value_we) begin
         value_mem[wr_req.addr] <= wr_req.value;
      end
      if (rd_req.en) begin
         value_rd_ff <= value_mem[rd_req.addr];
      end
   end

   // Mark a slot live on its first state write; reset empties the whole table
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (wr_req.slot_we) begin
         live_ff[wr_req.addr] <= 1'b1;
      end
   end

   // Sample the valid bit alongside the memory read
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         live_rd_ff <= live_ff[rd_req.addr];
      end
   end

   // A slot never written reads as empty
   always_comb begin
      rd_rsp.state = live_rd_ff ? slot_rd_ff.state : lphm_pkg::SLOT_EMPTY;
      rd_rsp.key   = slot_rd_ff.key;
      rd_rsp.value = value_rd_ff;
   end

endmodule

`default_nettype wire

### hdl/linear_probe_hash_map.sv
// Top level of the linear probing hash map: command sequencer, CSR and result register
//
//   channel | direction | handshake               | payload
//   req_    | in        | req_valid / req_ready   | command, key_id, key_hash, value
//   rsp_    | out       | rsp_valid / rsp_ready   | status, read_value, slot_index
//   csr_    | in/out    | psel, penable, pready   | paddr, pwdata, prdata (max_entries)
//
// A command probes P slots, P the number of slots probed (1..CAPACITY), in these steps:
// accept, start-slot reduction, one probe per cycle on the table read port, result hand-off.
// Early answers (table at load limit, lookup on empty table) skip the probes.
// Reset clears the slot valid bits at once; the first command is taken right after reset.
// A finished transaction sits in the output register; a new one is accepted while it waits,
// and only the hand-off cycle of the following command holds for rsp_ready.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_map_assert.svh"

module linear_probe_hash_map (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [lphm_pkg::CMD_W-1:0]         req_command,
   input  wire logic [lphm_pkg::KEY_W-1:0]         req_key_id,
   input  wire logic [lphm_pkg::HASH_W-1:0]        req_key_hash,
   input  wire logic [lphm_pkg::VALUE_W-1:0]       req_value,

   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic [lphm_pkg::STATUS_W-1:0]      rsp_status,
   output      logic [lphm_pkg::VALUE_W-1:0]       rsp_read_value,
   output      logic [lphm_pkg::OUT_SLOT_W-1:0]    rsp_slot_index,

   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lphm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [lphm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [lphm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                               csr_pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOD,
      S_EVAL,
      S_SEND
   } fsm_state_type;

   fsm_state_type                        state_ff;

   // Captured transaction
   lphm_pkg::cmd_type                    cmd_ff;
   logic [lphm_pkg::KEY_W-1:0]           key_ff;
   logic [lphm_pkg::HASH_W-1:0]          hash_ff;
   logic [lphm_pkg::VALUE_W-1:0]         value_ff;
   logic [lphm_pkg::PROD_W-1:0]          prod_ff;

   // Probe position
   logic [lphm_pkg::SLOT_W-1:0]          idx_ff;
   logic [lphm_pkg::CNT_W-1:0]           probe_ff;

   // Map bookkeeping
   logic [lphm_pkg::COUNT_W-1:0]         entry_count_ff;
   logic [lphm_pkg::COUNT_W-1:0]         max_entries_ff;

   // Pending result and output register
   lphm_pkg::status_type                 res_status_ff;
   logic [lphm_pkg::VALUE_W-1:0]         res_value_ff;
   logic [lphm_pkg::OUT_SLOT_W-1:0]      res_slot_ff;
   logic                                 rsp_valid_ff;
   lphm_pkg::status_type                 rsp_status_ff;
   logic [lphm_pkg::VALUE_W-1:0]         rsp_value_ff;
   logic [lphm_pkg::OUT_SLOT_W-1:0]      rsp_slot_ff;

   lphm_pkg::rd_req_type                 rd_req;
   lphm_pkg::rd_rsp_type                 rd_rsp;
   lphm_pkg::wr_req_type                 wr_req;

   logic [lphm_pkg::HASH_W-1:0]          mod_quot;
   logic [lphm_pkg::HASH_W-1:0]          mod_prod;
   logic [lphm_pkg::SLOT_W-1:0]          start_idx;
   logic [lphm_pkg::SLOT_W-1:0]          next_idx;
   logic                                 is_set;
   logic                                 at_limit;
   logic                                 table_empty;
   logic                                 is_used;
   logic                                 key_match;
   logic                                 last_probe;
   logic                                 found;
   logic                                 probe_done;
   logic                                 csr_write;
   logic                                 csr_hit;
   logic                                 out_free;

   lphm_table u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .rd_rsp (rd_rsp),
      .wr_req (wr_req)
   );

   // Reduce the hash to its start slot from the registered reciprocal product
   always_comb begin
      mod_quot  = lphm_pkg::HASH_W'(prod_ff >> lphm_pkg::RECIP_SH);
      mod_prod  = lphm_pkg::HASH_W'(mod_quot * lphm_pkg::HASH_W'(lphm_pkg::CAPACITY));
      start_idx = lphm_pkg::SLOT_W'(hash_ff - mod_prod);
      next_idx  = (idx_ff == lphm_pkg::SLOT_W'(lphm_pkg::CAPACITY - 1)) ?
                  '0 : idx_ff + 1'b1;
   end

   // Probe decision on the slot just read
   always_comb begin
      is_set      = (cmd_ff == lphm_pkg::CMD_SET);
      at_limit    = (entry_count_ff >= max_entries_ff);
      table_empty = (entry_count_ff == '0);
      is_used     = (rd_rsp.state == lphm_pkg::SLOT_USED);
      key_match   = (rd_rsp.key == key_ff);
      last_probe  = (probe_ff == lphm_pkg::CNT_W'(lphm_pkg::CAPACITY - 1));
      found       = is_set ? (!is_used || key_match) : (is_used && key_match);
      probe_done  = found || last_probe ||
                    (!is_set && rd_rsp.state == lphm_pkg::SLOT_EMPTY);
   end

   // Drive the table: read the start slot, then one slot per cycle; write the slot a command settles on
   always_comb begin
      rd_req.en      = 1'b0;
      rd_req.addr    = start_idx;
      wr_req.slot_we = 1'b0;
      wr_req.value_we = 1'b0;
      wr_req.addr    = idx_ff;
      wr_req.state   = lphm_pkg::SLOT_USED;
      wr_req.key     = key_ff;
      wr_req.value   = value_ff;
      unique case (state_ff)
         S_MOD: begin
            rd_req.en = !(is_set ? at_limit : table_empty);
         end
         S_EVAL: begin
            if (!probe_done) begin
               rd_req.en   = 1'b1;
               rd_req.addr = next_idx;
            end
            if (found) begin
               unique case (cmd_ff)
                  lphm_pkg::CMD_SET: begin
                     wr_req.value_we = 1'b1;
                     wr_req.slot_we  = !is_used;
                  end
                  lphm_pkg::CMD_SET_EXISTING: begin
                     wr_req.value_we = 1'b1;
                  end
                  lphm_pkg::CMD_DELETE: begin
                     wr_req.slot_we = 1'b1;
                     wr_req.state   = lphm_pkg::SLOT_DELETED;
                  end
                  lphm_pkg::CMD_GET: begin
                  end
               endcase
            end
         end
         S_IDLE, S_SEND: begin
         end
      endcase
   end

   // Handshakes and CSR decode
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      out_free   = !rsp_valid_ff || rsp_ready;
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      csr_hit    = (csr_paddr[lphm_pkg::CSR_ADDR_W-1:2] ==
                    lphm_pkg::CSR_IDX_W'(lphm_pkg::REG_MAX_ENTRIES));
      csr_prdata = csr_hit ? lphm_pkg::CSR_DATA_W'(max_entries_ff) : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_slot_index = rsp_slot_ff;

   // Sequencer, counters and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
         max_entries_ff <= lphm_pkg::MAX_ENTRIES_RESET;
      end else begin
         // Take a configuration write
         if (csr_write && csr_hit) begin
            max_entries_ff <= csr_pwdata[lphm_pkg::COUNT_W-1:0];
         end

         // Raise valid on hand-off, drop it once the consumer takes the result
         if (state_ff == S_SEND && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= lphm_pkg::cmd_type'(req_command);
                  key_ff   <= req_key_id;
                  hash_ff  <= req_key_hash;
                  value_ff <= req_value;
                  prod_ff  <= lphm_pkg::PROD_W'(req_key_hash * lphm_pkg::RECIP_M);
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               idx_ff   <= start_idx;
               probe_ff <= '0;
               res_value_ff <= '0;
               res_slot_ff  <= '0;
               if (is_set && at_limit) begin
                  res_status_ff <= lphm_pkg::STATUS_FULL;
                  state_ff      <= S_SEND;
               end else if (!is_set && table_empty) begin
                  res_status_ff <= lphm_pkg::STATUS_NOT_FOUND;
                  state_ff      <= S_SEND;
               end else begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               idx_ff   <= next_idx;
               probe_ff <= probe_ff + 1'b1;
               if (probe_done) begin
                  state_ff <= S_SEND;
                  if (found) begin
                     res_status_ff <= lphm_pkg::STATUS_DONE;
                     res_slot_ff   <= lphm_pkg::OUT_SLOT_W'(idx_ff);
                     res_value_ff  <= (cmd_ff == lphm_pkg::CMD_GET) ? rd_rsp.value : '0;
                  end else begin
                     res_status_ff <= is_set ? lphm_pkg::STATUS_FULL :
                                               lphm_pkg::STATUS_NOT_FOUND;
                     res_slot_ff   <= '0;
                     res_value_ff  <= '0;
                  end
                  if (is_set && found && !is_used) begin
                     entry_count_ff <= entry_count_ff + 1'b1;
                  end
               end
            end
            S_SEND: begin
               if (out_free) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_value_ff  <= res_value_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  state_ff      <= S_IDLE;
               end
            end
         endcase
      end
   end

   // Table writes come only from a probe decision
   `LPHM_ASSERT_NOW(a_write_in_probe, wr_req.slot_we || wr_req.value_we, state_ff == S_EVAL)
   // The probe count stays within one lap of the table
   `LPHM_ASSERT_NOW(a_probe_bound, state_ff == S_EVAL, probe_ff < lphm_pkg::CNT_W'(lphm_pkg::CAPACITY))
   // Filling a fresh slot raises the entry count by one
   `LPHM_ASSERT_NEXT(a_count_step, wr_req.slot_we && wr_req.state == lphm_pkg::SLOT_USED, entry_count_ff == $past(entry_count_ff) + 1'b1)
   // A new result appears only from the hand-off state
   `LPHM_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff) == S_SEND)

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the linear probing hash map
`timescale 1ns / 1ps

module tb_top;
   import lphm_pkg::*;

   localparam int POOL_KEYS = 24;
   localparam int RANDOM_ITEMS = 260;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 80;
   localparam int RECEIVER_HOLD = 300;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_MAX_ENTRIES);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = CSR_ADDR_W'(4 * (REG_MAX_ENTRIES + 1));

   typedef struct {
      status_type              status;
      logic [VALUE_W-1:0]      read_value;
      logic [OUT_SLOT_W-1:0]   slot_index;
   } map_answer_type;

   // DUT ports, every input driven to a known value from time zero
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_command = '0;
   logic [KEY_W-1:0]           req_key_id = '0;
   logic [HASH_W-1:0]          req_key_hash = '0;
   logic [VALUE_W-1:0]         req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [VALUE_W-1:0]         rsp_read_value;
   logic [OUT_SLOT_W-1:0]      rsp_slot_index;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   // Shadow copy of the table and its limit register
   slot_state_type             tbl_state [CAPACITY];
   logic [KEY_W-1:0]           tbl_key [CAPACITY];
   logic [VALUE_W-1:0]         tbl_value [CAPACITY];
   logic [COUNT_W-1:0]         stored_count = '0;
   logic [COUNT_W-1:0]         load_limit = MAX_ENTRIES_RESET;
   map_answer_type             pending_answers [$];

   // Key pool for random traffic: each key keeps one hash
   logic [KEY_W-1:0]           pool_key [POOL_KEYS];
   logic [HASH_W-1:0]          pool_hash [POOL_KEYS];

   int                         src_idle_pct = 32;
   int                         sink_idle_pct = 53;
   int                         stall_cycles = 0;
   int                         mismatches = 0;
   int                         stuck_cycles = 0;

   linear_probe_hash_map dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_key_id     (req_key_id),
      .req_key_hash   (req_key_hash),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_slot_index (rsp_slot_index),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < 40) begin
         $display("%0t mismatch: %s", $time, what);
      end
      mismatches++;
   endtask

   // Apply one command to the shadow table and return the answer it must give
   function automatic map_answer_type apply_map_command(input cmd_type cmd,
                                                        input logic [KEY_W-1:0] key,
                                                        input logic [HASH_W-1:0] hash,
                                                        input logic [VALUE_W-1:0] val);
      map_answer_type ans;
      int unsigned pos;
      int found;
      bit halted;
      ans.status = STATUS_NOT_FOUND;
      ans.read_value = '0;
      ans.slot_index = '0;
      found = -1;
      halted = 1'b0;
      pos = hash % CAPACITY;
      if (cmd == CMD_SET) begin
         if (stored_count >= load_limit) begin
            ans.status = STATUS_FULL;
         end else begin
            // first slot that is free, a tombstone, or already holds the key
            for (int n = 0; n < CAPACITY && found < 0; n++) begin
               if (tbl_state[pos] != SLOT_USED || tbl_key[pos] == key) begin
                  found = pos;
               end else begin
                  pos = (pos + 1) % CAPACITY;
               end
            end
            if (found < 0) begin
               ans.status = STATUS_FULL;
            end else begin
               tbl_value[found] = val;
               if (tbl_state[found] != SLOT_USED) begin
                  tbl_state[found] = SLOT_USED;
                  tbl_key[found] = key;
                  stored_count = stored_count + 1'b1;
               end
               ans.status = STATUS_DONE;
            end
         end
      end else if (stored_count != 0) begin
         // pass over tombstones, stop at a truly empty slot
         for (int n = 0; n < CAPACITY && found < 0 && !halted; n++) begin
            if (tbl_state[pos] == SLOT_USED && tbl_key[pos] == key) begin
               found = pos;
            end else if (tbl_state[pos] == SLOT_EMPTY) begin
               halted = 1'b1;
            end else begin
               pos = (pos + 1) % CAPACITY;
            end
         end
         if (found >= 0) begin
            ans.status = STATUS_DONE;
            case (cmd)
               CMD_SET_EXISTING: begin
                  tbl_value[found] = val;
               end
               CMD_GET: begin
                  ans.read_value = tbl_value[found];
               end
               default: begin
                  tbl_state[found] = SLOT_DELETED;
               end
            endcase
         end
      end
      if (found >= 0) begin
         ans.slot_index = OUT_SLOT_W'(found);
      end
      return ans;
   endfunction

   // Offer one command; return right after the edge that accepts it
   task automatic send_command(input cmd_type cmd, input logic [KEY_W-1:0] key,
                               input logic [HASH_W-1:0] hash, input logic [VALUE_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key_id <= key;
      req_key_hash <= hash;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(apply_map_command(cmd, key, hash, val));
   endtask

   // Mostly well-formed traffic on the key pool, a little noise
   task automatic send_random_command();
      int unsigned pick;
      int unsigned k;
      cmd_type cmd;
      logic [KEY_W-1:0] key;
      logic [HASH_W-1:0] hash;
      logic [VALUE_W-1:0] val;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, POOL_KEYS - 1);
      key = pool_key[k];
      hash = pool_hash[k];
      val = {$urandom, $urandom};
      if (pick < 4) begin
         cmd = cmd_type'($urandom_range(0, 3));
         key = $urandom;
         hash = $urandom;
      end else if (pick < 7) begin
         cmd = CMD_DELETE;
      end else if (pick < 40) begin
         cmd = CMD_GET;
      end else if (pick < 60) begin
         cmd = CMD_SET_EXISTING;
      end else begin
         cmd = CMD_SET;
      end
      if ($urandom_range(0, 15) == 0) begin
         val = $urandom_range(0, 1) ? '1 : '0;
      end
      send_command(cmd, key, hash, val);
   endtask

   // Hold the input idle until every expected answer has come back
   task automatic wait_answers_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Write a register, then read the limit back
   task automatic program_limit(input logic [CSR_ADDR_W-1:0] addr,
                                input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((addr >> 2) == REG_MAX_ENTRIES) begin
         load_limit = data[COUNT_W-1:0];
      end
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= LIMIT_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(load_limit)) begin
         report_mismatch($sformatf("limit reads %0d, want %0d", csr_prdata, load_limit));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_empty_lookups();
      send_command(CMD_SET_EXISTING, 32'h0000_0001, 32'h0, '1);
      send_command(CMD_GET, 32'h0000_0001, 32'h0, '0);
      send_command(CMD_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      send_command(CMD_GET, '0, 32'h0000_0040, '0);
   endtask

   task automatic test_limit_register();
      wait_answers_drained();
      // upper data bits fall outside the 7-bit field: limit becomes zero
      program_limit(LIMIT_ADDR, 32'hFFFF_FF80);
      send_command(CMD_SET, 32'h0000_0011, 32'h0000_0005, 64'h1);
      wait_answers_drained();
      program_limit(UNMAPPED_ADDR, 32'h0000_0030);
      send_command(CMD_SET, 32'h0000_0011, 32'h0000_0005, 64'h2);
      wait_answers_drained();
      program_limit(LIMIT_ADDR, 32'h0000_007F);
   endtask

   task automatic test_probe_wrap_and_tombstones();
      logic [KEY_W-1:0] key_a;
      logic [KEY_W-1:0] key_b;
      key_a = 32'hFFFF_FFFF;
      key_b = 32'h8000_0000;
      // both start at the last slot; the second wraps to slot zero
      send_command(CMD_SET, key_a, 32'hFFFF_FFFF, '1);
      send_command(CMD_SET, key_b, 32'h0000_003F, '0);
      send_command(CMD_SET, key_a, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
      send_command(CMD_GET, key_b, 32'h0000_003F, '0);
      send_command(CMD_GET, key_a, 32'hFFFF_FFFF, '0);
      send_command(CMD_SET_EXISTING, key_b, 32'h0000_003F, 64'hA5A5_A5A5_5A5A_5A5A);
      send_command(CMD_SET_EXISTING, 32'h0000_0001, 32'h0000_003F, '1);
      // tombstone in front of a live key is passed over, then reused
      send_command(CMD_DELETE, key_a, 32'hFFFF_FFFF, '0);
      send_command(CMD_GET, key_b, 32'h0000_003F, '0);
      send_command(CMD_SET, key_b, 32'h0000_003F, 64'h8000_0000_0000_0001);
      send_command(CMD_GET, key_b, 32'h0000_003F, '0);
      send_command(CMD_DELETE, key_b, 32'h0000_003F, '0);
      send_command(CMD_GET, key_b, 32'h0000_003F, '0);
      send_command(CMD_DELETE, key_b, 32'h0000_003F, '0);
      send_command(CMD_GET, key_b, 32'h0000_003F, '0);
      // key id zero behaves like any other id
      send_command(CMD_SET, '0, 32'h0000_0040, 64'h0000_0000_FFFF_FFFF);
      send_command(CMD_GET, '0, 32'h0000_0040, '0);
      send_command(CMD_GET, '0, 32'h0000_0001, '0);
   endtask

   task automatic test_load_limit();
      wait_answers_drained();
      program_limit(LIMIT_ADDR, CSR_DATA_W'(stored_count));
      // refused even though the key is present
      send_command(CMD_SET, '0, 32'h0000_0040, '1);
      send_command(CMD_SET, 32'h0000_0022, 32'h0000_0007, '1);
      wait_answers_drained();
      program_limit(LIMIT_ADDR, 32'h0000_007F);
   endtask

   task automatic test_receiver_stall();
      // long receiver hold-off while the sender keeps offering
      stall_cycles = RECEIVER_HOLD;
      repeat (30) send_random_command();
   endtask

   task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                      input logic [CSR_DATA_W-1:0] limit);
      wait_answers_drained();
      src_idle_pct = src_pct;
      sink_idle_pct = sink_pct;
      program_limit(LIMIT_ADDR, limit);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            wait_answers_drained();
         end
         send_random_command();
      end
   endtask

   task automatic test_full_table();
      wait_answers_drained();
      program_limit(LIMIT_ADDR, 32'h0000_007F);
      // occupy every free slot so no set can find room
      for (int s = 0; s < CAPACITY; s++) begin
         if (tbl_state[s] != SLOT_USED) begin
            send_command(CMD_SET, 32'hC0DE_0000 | s, ($urandom & 32'hFFFF_FFC0) | s,
                         {$urandom, $urandom});
         end
      end
      send_command(CMD_SET, 32'h7777_0001, $urandom, '1);
      send_command(CMD_GET, 32'h7777_0001, $urandom, '0);
      send_command(CMD_SET_EXISTING, 32'h7777_0002, $urandom, '1);
      send_command(CMD_DELETE, tbl_key[10], 32'h0000_000A, '0);
      send_command(CMD_SET, 32'h7777_0003, 32'h0000_0003, 64'hDEAD_BEEF_0000_0001);
      send_command(CMD_GET, 32'h7777_0003, 32'h0000_0003, '0);
   endtask

   // Receiver: long hold when asked, otherwise random stalls
   always @(negedge clock) begin
      if (stall_cycles > 0) begin
         stall_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   // Check each returned transaction against the oldest expectation
   always @(posedge clock) begin
      map_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("answer with nothing outstanding");
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            end
            if (rsp_read_value !== want.read_value) begin
               report_mismatch($sformatf("read_value %h, want %h", rsp_read_value,
                                         want.read_value));
            end
            if (rsp_slot_index !== want.slot_index) begin
               report_mismatch($sformatf("slot_index %0d, want %0d", rsp_slot_index,
                                         want.slot_index));
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("[linear_probe_hash_map] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      foreach (tbl_state[i]) begin
         tbl_state[i] = SLOT_EMPTY;
         tbl_key[i] = '0;
         tbl_value[i] = '0;
      end
      // pool keys cluster around the end of the table so probes wrap
      foreach (pool_key[i]) begin
         pool_key[i] = $urandom_range(1, 32'hFFFF_FFFF);
         pool_hash[i] = ($urandom & 32'hFFFF_FFC0) | ($urandom_range(52, 75) % CAPACITY);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_lookups();
      test_limit_register();
      test_probe_wrap_and_tombstones();
      test_load_limit();
      test_receiver_stall();
      test_random_traffic(32, 53, 32'h0000_007F);
      test_random_traffic(53, 32, 32'h0000_0040);
      test_random_traffic(0, 0, 32'h0000_007F);
      test_full_table();

      wait_answers_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[linear_probe_hash_map] OK");
      end else begin
         $display("[linear_probe_hash_map] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/lphm_pkg.sv
hdl/lphm_table.sv
hdl/linear_probe_hash_map.sv
sim/tb_top.sv
